// ----- sv/wlpl_pkg.sv -----
// Shared types and constants for the wear-level position log.
package wlpl_pkg;

    localparam int SLOT_W = 6;
    localparam int SEQ_W  = 8;
    localparam int POS_W  = 8;

    localparam logic [SEQ_W-1:0] ERASED_SEQ = 8'hFF;
    localparam logic [SEQ_W-1:0] HALF_RANGE = 8'h80;
    localparam logic [SEQ_W-1:0] FIRST_SEQ  = 8'h01;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_STORE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic             cmd;
        logic [POS_W-1:0] position;
    } in_t;

    typedef struct packed {
        logic [POS_W-1:0]  newest_position;
        logic              found;
        logic [SLOT_W-1:0] slot_written;
        logic [SEQ_W-1:0]  seq_written;
    } out_t;

    // Running newest-slot state kept by the compare unit
    typedef struct packed {
        logic              any;
        logic [SEQ_W-1:0]  seq;
        logic [POS_W-1:0]  pos;
        logic [SLOT_W-1:0] slot;
    } best_t;

endpackage

// ----- sv/wlpl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wlpl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/wlpl_cmp.sv -----
// Shared sequence compare unit: tracks the newest non-empty slot over a scan.
module wlpl_cmp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      clear,
    input  logic                      en,
    input  logic [wlpl_pkg::SEQ_W-1:0]  seq,
    input  logic [wlpl_pkg::POS_W-1:0]  pos,
    input  logic [wlpl_pkg::SLOT_W-1:0] idx,
    output wlpl_pkg::best_t           best
);
    import wlpl_pkg::*;

    best_t            best_reg;
    best_t            best_next;
    logic [SEQ_W-1:0] diff;
    logic             take;

    // Modular distance below half range means newer; ties go to the later slot
    assign diff = seq - best_reg.seq;
    assign take = (seq != ERASED_SEQ) && (!best_reg.any || (diff < HALF_RANGE));

    always_comb begin
        best_next = best_reg;
        if (clear) begin
            best_next = '0;
        end else if (en && take) begin
            best_next.any  = 1'b1;
            best_next.seq  = seq;
            best_next.pos  = pos;
            best_next.slot = idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg <= '0;
        end else begin
            best_reg <= best_next;
        end
    end

    assign best = best_reg;

endmodule

// ----- sv/wear_level_position_log.sv -----
// Top level of the wear-level position log: sequencer, slot RAM and compare unit.
//
// Each command (load or store) scans every slot for the newest entry, one slot
// per cycle through a single sequence comparator fed by the slot RAM's
// registered read port, then finishes in a finish state that writes the new
// slot on a store and loads the result register. s_ready is low from
// acceptance until the result is loaded, and the block takes one item at a
// time. The finish state waits while an earlier result is still held on the
// m_ side. Slots read as erased after reset through per-slot valid flags, so
// no clearing pass is needed.
module wear_level_position_log #(
    parameter int SLOT_COUNT = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  wlpl_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output wlpl_pkg::out_t m_data
);
    import wlpl_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(SLOT_COUNT);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [IDX_W-1:0]  eval_idx_reg, eval_idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              slot_vld_q_reg, slot_vld_q_next;
    logic [SLOT_COUNT-1:0] valid_reg, valid_next;
    logic              cmd_reg, cmd_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    logic [IDX_W-1:0]  raddr;
    logic [SEQ_W+POS_W-1:0] rdata;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [SLOT_W-1:0] wslot;
    logic [SEQ_W-1:0]  wseq;
    logic              cmp_clear;
    logic              cmp_en;
    logic [SEQ_W-1:0]  cmp_seq;
    best_t             best;
    logic              accept;
    logic              out_free;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign raddr    = scan_cnt_reg[IDX_W-1:0];

    // A slot never written reads as erased
    assign cmp_seq   = slot_vld_q_reg ? rdata[SEQ_W+POS_W-1:POS_W] : ERASED_SEQ;
    assign cmp_en    = (state_reg == ST_SCAN) && rd_vld_reg;
    assign cmp_clear = accept;

    always_comb begin
        if (!best.any) begin
            wslot = '0;
            wseq  = FIRST_SEQ;
        end else begin
            wslot = (best.slot == LAST_SLOT) ? '0 : best.slot + 1'b1;
            wseq  = best.seq + 1'b1;
        end
    end

    assign waddr = wslot[IDX_W-1:0];
    assign we    = (state_reg == ST_FINISH) && out_free && (cmd_reg == CMD_STORE);

    wlpl_ram #(
        .WIDTH (SEQ_W + POS_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata ({wseq, pos_reg}),
        .raddr (raddr),
        .rdata (rdata)
    );

    wlpl_cmp u_cmp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (cmp_clear),
        .en      (cmp_en),
        .seq     (cmp_seq),
        .pos     (rdata[POS_W-1:0]),
        .idx     (SLOT_W'(eval_idx_reg)),
        .best    (best)
    );

    always_comb begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        eval_idx_next   = eval_idx_reg;
        rd_vld_next     = 1'b0;
        slot_vld_q_next = slot_vld_q_reg;
        valid_next      = valid_reg;
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next      = s_data.cmd;
                    pos_next      = s_data.position;
                    scan_cnt_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue one slot read per cycle; evaluate it the cycle after
                if (scan_cnt_reg < CNT_END) begin
                    rd_vld_next     = 1'b1;
                    eval_idx_next   = raddr;
                    slot_vld_q_next = valid_reg[raddr];
                    scan_cnt_next   = scan_cnt_reg + 1'b1;
                end else if (rd_vld_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Hold until the previous result has been taken
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.newest_position = best.any ? best.pos : '0;
                    m_data_next.found           = best.any;
                    m_data_next.slot_written    = '0;
                    m_data_next.seq_written     = '0;
                    if (cmd_reg == CMD_STORE) begin
                        valid_next[waddr]        = 1'b1;
                        m_data_next.slot_written = wslot;
                        m_data_next.seq_written  = wseq;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_vld_reg  <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
        scan_cnt_reg   <= scan_cnt_next;
        eval_idx_reg   <= eval_idx_next;
        slot_vld_q_reg <= slot_vld_q_next;
        cmd_reg        <= cmd_next;
        pos_reg        <= pos_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- sv/wlpl_checker.sv -----
// Port-level checks for the wear-level position log, bound to the top level.
module wlpl_checker #(
    parameter int SLOT_COUNT = 8
) (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input wlpl_pkg::out_t m_data
);
    import wlpl_pkg::*;

    // A stalled result transfer holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // The block is busy scanning right after taking an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a transfer");

    // Nothing found means position reads zero, and a store starts at slot zero
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.newest_position == '0
            && m_data.slot_written == '0
            && (m_data.seq_written == '0 || m_data.seq_written == FIRST_SEQ))
        else $error("bad result for empty ring");

    // Written slot stays inside the ring
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.slot_written < SLOT_W'(SLOT_COUNT - 1) + 1'b1
            || m_data.slot_written == SLOT_W'(SLOT_COUNT - 1))
        else $error("slot index beyond ring");

endmodule

bind wear_level_position_log wlpl_checker #(.SLOT_COUNT(SLOT_COUNT)) u_wlpl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
